// ===== hw/rtl/psd_pkg.sv =====
// shared constants, types and register map of the point to segment distance block
package psd_pkg;

  localparam int COORD_WIDTH_DEF = 32;
  localparam int TOL_WIDTH       = 16;
  localparam int QUEUE_DEPTH     = 4;
  localparam int PADDR_WIDTH     = 3;
  localparam int PDATA_WIDTH     = 32;

  // register index, taken from paddr bit 2
  localparam logic REG_TOL_IDX = 1'b0;

  typedef enum logic [1:0] {
    PART_START    = 2'd0,
    PART_END      = 2'd1,
    PART_INTERIOR = 2'd2,
    PART_DEGEN    = 2'd3
  } part_e;

endpackage

// ===== hw/rtl/psd_front.sv =====
// front pipeline: differences, products, case selection and squared numerator
module psd_front #(
  parameter int COORD_WIDTH = psd_pkg::COORD_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [6*COORD_WIDTH-1:0]      in_data_i,
  input  logic [psd_pkg::TOL_WIDTH-1:0] tol_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [4*COORD_WIDTH+1:0]      out_num_o,
  output logic [2*COORD_WIDTH:0]        out_den_o,
  output psd_pkg::part_e                out_part_o
);
  import psd_pkg::*;

  localparam int W  = COORD_WIDTH;
  localparam int DW = W + 1;
  localparam int PW = 2 * DW;
  localparam int LW = 2 * W + 1;
  localparam int NW = 2 * LW;
  localparam int H  = W + 1;
  localparam int TW = (DW > TOL_WIDTH) ? DW : TOL_WIDTH;

  function automatic logic [DW-1:0] absv(logic [DW-1:0] v);
    return v[DW-1] ? DW'(~v + DW'(1)) : v;
  endfunction

  logic en;
  logic v1_q, v2_q, v3_q, v4_q, v5_q, v6_q;

  assign en          = !(v6_q && !out_ready_i);
  assign in_ready_o  = en;
  assign out_valid_o = v6_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
      v6_q <= v5_q;
    end
  end

  // stage 1: coordinate differences and degenerate test
  logic [W-1:0] px, py, sx, sy, ex, ey;
  logic [DW-1:0] segx_d, segy_d, relx_d, rely_d, erx_d, ery_d;
  logic degen_d;

  assign px = in_data_i[0*W +: W];
  assign py = in_data_i[1*W +: W];
  assign sx = in_data_i[2*W +: W];
  assign sy = in_data_i[3*W +: W];
  assign ex = in_data_i[4*W +: W];
  assign ey = in_data_i[5*W +: W];

  assign segx_d = {ex[W-1], ex} - {sx[W-1], sx};
  assign segy_d = {ey[W-1], ey} - {sy[W-1], sy};
  assign relx_d = {px[W-1], px} - {sx[W-1], sx};
  assign rely_d = {py[W-1], py} - {sy[W-1], sy};
  assign erx_d  = {px[W-1], px} - {ex[W-1], ex};
  assign ery_d  = {py[W-1], py} - {ey[W-1], ey};

  assign degen_d = (TW'(absv(segx_d)) <= TW'(tol_i)) && (TW'(absv(segy_d)) <= TW'(tol_i));

  logic signed [DW-1:0] segx_q, segy_q, relx_q, rely_q, erx_q, ery_q;
  logic degen1_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      segx_q   <= segx_d;
      segy_q   <= segy_d;
      relx_q   <= relx_d;
      rely_q   <= rely_d;
      erx_q    <= erx_d;
      ery_q    <= ery_d;
      degen1_q <= degen_d;
    end
  end

  // stage 2: one product per register
  logic signed [PW-1:0] sxx_q, syy_q, rxsx_q, rysy_q, rysx_q, rxsy_q;
  logic signed [PW-1:0] rxx_q, ryy_q, exx_q, eyy_q;
  logic degen2_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      sxx_q    <= segx_q * segx_q;
      syy_q    <= segy_q * segy_q;
      rxsx_q   <= relx_q * segx_q;
      rysy_q   <= rely_q * segy_q;
      rysx_q   <= rely_q * segx_q;
      rxsy_q   <= relx_q * segy_q;
      rxx_q    <= relx_q * relx_q;
      ryy_q    <= rely_q * rely_q;
      exx_q    <= erx_q * erx_q;
      eyy_q    <= ery_q * ery_q;
      degen2_q <= degen1_q;
    end
  end

  // stage 3: squared length, dot and cross products, endpoint distances
  logic [PW-1:0] l2_sum, d2s_sum, d2e_sum, dot_sum, cr_sum;

  assign l2_sum  = sxx_q + syy_q;
  assign d2s_sum = rxx_q + ryy_q;
  assign d2e_sum = exx_q + eyy_q;
  assign dot_sum = rxsx_q + rysy_q;
  assign cr_sum  = rysx_q - rxsy_q;

  logic [LW-1:0] l2_q, d2s_q, d2e_q;
  logic [PW-1:0] dot_q, cr_q;
  logic degen3_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      l2_q     <= l2_sum[LW-1:0];
      d2s_q    <= d2s_sum[LW-1:0];
      d2e_q    <= d2e_sum[LW-1:0];
      dot_q    <= dot_sum;
      cr_q     <= cr_sum;
      degen3_q <= degen2_q;
    end
  end

  // stage 4: classify against the projection bounds
  logic dot_le0, dot_ge;
  logic [PW-1:0] cr_abs;
  part_e part4_d;
  logic [LW-1:0] den4_d, d24_d;

  assign dot_le0 = dot_q[PW-1] || (dot_q == '0);
  assign dot_ge  = $signed(dot_q) >= $signed({1'b0, l2_q});
  assign cr_abs  = cr_q[PW-1] ? PW'(~cr_q + PW'(1)) : cr_q;

  always_comb begin
    den4_d  = LW'(1);
    d24_d   = d2s_q;
    part4_d = PART_DEGEN;
    if (degen3_q) begin
      part4_d = PART_DEGEN;
    end else if (dot_le0) begin
      part4_d = PART_START;
    end else if (dot_ge) begin
      part4_d = PART_END;
      d24_d   = d2e_q;
    end else begin
      part4_d = PART_INTERIOR;
      den4_d  = l2_q;
    end
  end

  logic [LW-1:0] den4_q, d24_q, cr4_q;
  part_e part4_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      den4_q  <= den4_d;
      d24_q   <= d24_d;
      cr4_q   <= cr_abs[LW-1:0];
      part4_q <= part4_d;
    end
  end

  // stage 5: cross squared as partial products of its halves
  logic [2*W-1:0] hh_q;
  logic [2*W:0]   hl_q;
  logic [2*H-1:0] ll_q;
  logic [LW-1:0]  den5_q, d25_q;
  part_e part5_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      hh_q    <= cr4_q[LW-1:H] * cr4_q[LW-1:H];
      hl_q    <= cr4_q[LW-1:H] * cr4_q[H-1:0];
      ll_q    <= cr4_q[H-1:0] * cr4_q[H-1:0];
      den5_q  <= den4_q;
      d25_q   <= d24_q;
      part5_q <= part4_q;
    end
  end

  // stage 6: numerator for the divider, squared distance where the divisor is one
  logic [NW-1:0] num_d;

  assign num_d = (part5_q == PART_INTERIOR) ?
                 (NW'(hh_q) << (2 * H)) + (NW'(hl_q) << (H + 1)) + NW'(ll_q) :
                 NW'(d25_q);

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_num_o  <= num_d;
      out_den_o  <= den5_q;
      out_part_o <= part5_q;
    end
  end

endmodule

// ===== hw/rtl/psd_queue.sv =====
// short first-in first-out queue between front and back pipelines
module psd_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = psd_pkg::QUEUE_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output logic [WIDTH-1:0] pop_data_o
);
  import psd_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [AW:0] count_q;
  logic push, pop;

  assign push_ready_o = (count_q != (AW + 1)'(DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
      end
      if (push && !pop) begin
        count_q <= count_q + (AW + 1)'(1);
      end else if (pop && !push) begin
        count_q <= count_q - (AW + 1)'(1);
      end
    end
  end

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= (AW + 1)'(DEPTH))
    else $error("queue fill count beyond depth");

  a_count_up : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> (count_q == $past(count_q) + (AW + 1)'(1)))
    else $error("queue fill count missed a push");

  a_ptr_gap : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0) |-> (wr_ptr_q == rd_ptr_q))
    else $error("queue pointers apart while empty");

endmodule

// ===== hw/rtl/psd_back.sv =====
// back pipeline: one quotient bit per stage, then one root bit per stage
module psd_back #(
  parameter int COORD_WIDTH = psd_pkg::COORD_WIDTH_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [4*COORD_WIDTH+1:0] in_num_i,
  input  logic [2*COORD_WIDTH:0]   in_den_i,
  input  psd_pkg::part_e           in_part_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [COORD_WIDTH:0]     out_dist_o,
  output psd_pkg::part_e           out_part_o
);
  import psd_pkg::*;

  localparam int W  = COORD_WIDTH;
  localparam int LW = 2 * W + 1;
  localparam int QW = LW;
  localparam int NW = 2 * LW;

  logic adv;

  // divider stages, remainder and quotient share one shifting word
  logic          div_v_q    [QW+1];
  logic [NW-1:0] div_rq_q   [QW+1];
  logic [LW-1:0] div_den_q  [QW+1];
  part_e         div_part_q [QW+1];

  // root stages, the last one is the output register
  logic           sq_v_q    [W+1];
  logic [W+1:0]   sq_rem_q  [W+1];
  logic [W:0]     sq_root_q [W+1];
  logic [2*W+1:0] sq_val_q  [W+1];
  part_e          sq_part_q [W+1];

  assign adv         = !sq_v_q[W] || out_ready_i;
  assign in_ready_o  = adv;
  assign out_valid_o = sq_v_q[W];
  assign out_dist_o  = sq_root_q[W];
  assign out_part_o  = sq_part_q[W];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_v_q[0] <= 1'b0;
    end else if (adv) begin
      div_v_q[0] <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      div_rq_q[0]   <= in_num_i;
      div_den_q[0]  <= in_den_i;
      div_part_q[0] <= in_part_i;
    end
  end

  for (genvar k = 0; k < QW; k++) begin : g_div
    logic [LW:0] t, diff;
    logic ge;

    assign t    = div_rq_q[k][NW-1:QW-1];
    assign diff = t - {1'b0, div_den_q[k]};
    assign ge   = (t >= {1'b0, div_den_q[k]});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        div_v_q[k+1] <= 1'b0;
      end else if (adv) begin
        div_v_q[k+1] <= div_v_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        div_rq_q[k+1]   <= {(ge ? diff[LW-1:0] : t[LW-1:0]), div_rq_q[k][QW-2:0], ge};
        div_den_q[k+1]  <= div_den_q[k];
        div_part_q[k+1] <= div_part_q[k];
      end
    end
  end

  for (genvar j = 0; j <= W; j++) begin : g_sqrt
    logic           v_in;
    logic [W+1:0]   rem_in;
    logic [W:0]     root_in;
    logic [2*W+1:0] val_in;
    part_e          p_in;
    logic [W+3:0]   t, trial, diff;
    logic           ge;

    if (j == 0) begin : g_first
      assign v_in    = div_v_q[QW];
      assign rem_in  = '0;
      assign root_in = '0;
      assign val_in  = {1'b0, div_rq_q[QW][QW-1:0]};
      assign p_in    = div_part_q[QW];
    end else begin : g_next
      assign v_in    = sq_v_q[j-1];
      assign rem_in  = sq_rem_q[j-1];
      assign root_in = sq_root_q[j-1];
      assign val_in  = sq_val_q[j-1];
      assign p_in    = sq_part_q[j-1];
    end

    assign t     = {rem_in, val_in[2*W+1:2*W]};
    assign trial = {1'b0, root_in, 2'b01};
    assign diff  = t - trial;
    assign ge    = (t >= trial);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sq_v_q[j] <= 1'b0;
      end else if (adv) begin
        sq_v_q[j] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        sq_rem_q[j]  <= ge ? diff[W+1:0] : t[W+1:0];
        sq_root_q[j] <= {root_in[W-1:0], ge};
        sq_val_q[j]  <= {val_in[2*W-1:0], 2'b00};
        sq_part_q[j] <= p_in;
      end
    end
  end

endmodule

// ===== hw/rtl/point_to_segment_distance.sv =====
// top level of the point to segment distance block: stream ports, register port, pipelines
// throughput: one word per cycle unless the output stalls,
// set by the fully pipelined divider and root stages
// front (6 stages) and back (quotient and root stages) are parted by a 4-entry queue
// a stalled output freezes only the back, the front keeps accepting until the queue fills
// reset: asynchronous, active low, clears valid bits, queue pointers and the tolerance
module point_to_segment_distance #(
  parameter int COORD_WIDTH = psd_pkg::COORD_WIDTH_DEF
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  // register port
  input  logic                                     psel,
  input  logic                                     penable,
  input  logic                                     pwrite,
  input  logic [psd_pkg::PADDR_WIDTH-1:0]          paddr,
  input  logic [psd_pkg::PDATA_WIDTH-1:0]          pwdata,
  output logic [psd_pkg::PDATA_WIDTH-1:0]          prdata,
  output logic                                     pready,
  // input words
  input  logic                                     s_axis_tvalid,
  output logic                                     s_axis_tready,
  // point_x, point_y, start_x, start_y, end_x, end_y, zero fill
  input  logic [((6*COORD_WIDTH+7)/8)*8-1:0]       s_axis_tdata,
  // result words
  output logic                                     m_axis_tvalid,
  input  logic                                     m_axis_tready,
  // distance, zero fill
  output logic [((COORD_WIDTH+8)/8)*8-1:0]         m_axis_tdata,
  // nearest_part
  output logic [1:0]                               m_axis_tuser
);
  import psd_pkg::*;

  localparam int W      = COORD_WIDTH;
  localparam int LW     = 2 * W + 1;
  localparam int NW     = 2 * LW;
  localparam int QDW    = 2 + LW + NW;
  localparam int OUT_TW = ((W + 8) / 8) * 8;

  // tolerance register, written in the access phase
  logic [TOL_WIDTH-1:0] tol_q;
  logic cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= '0;
    end else if (cfg_wr && (paddr[PADDR_WIDTH-1] == REG_TOL_IDX)) begin
      tol_q <= pwdata[TOL_WIDTH-1:0];
    end
  end

  assign prdata = (paddr[PADDR_WIDTH-1] == REG_TOL_IDX) ? PDATA_WIDTH'(tol_q) : '0;

  // front: differences, products, case choice and divider operands
  logic          f_valid, f_ready;
  logic [NW-1:0] f_num;
  logic [LW-1:0] f_den;
  part_e         f_part;

  psd_front #(
    .COORD_WIDTH(W)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_data_i   (s_axis_tdata[6*W-1:0]),
    .tol_i       (tol_q),
    .out_valid_o (f_valid),
    .out_ready_i (f_ready),
    .out_num_o   (f_num),
    .out_den_o   (f_den),
    .out_part_o  (f_part)
  );

  // queue word: numerator low, divisor, case code high
  logic           q_valid, q_ready;
  logic [QDW-1:0] q_data;

  psd_queue #(
    .WIDTH(QDW),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (f_valid),
    .push_ready_o (f_ready),
    .push_data_i  ({f_part, f_den, f_num}),
    .pop_valid_o  (q_valid),
    .pop_ready_i  (q_ready),
    .pop_data_o   (q_data)
  );

  // back: integer quotient then integer root, floor throughout
  logic [W:0] b_dist;
  part_e      b_part;

  psd_back #(
    .COORD_WIDTH(W)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (q_valid),
    .in_ready_o  (q_ready),
    .in_num_i    (q_data[NW-1:0]),
    .in_den_i    (q_data[NW +: LW]),
    .in_part_i   (part_e'(q_data[QDW-1 -: 2])),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_dist_o  (b_dist),
    .out_part_o  (b_part)
  );

  assign m_axis_tdata = OUT_TW'(b_dist);
  assign m_axis_tuser = b_part;

endmodule
